// ----- hdl/assert_macros.svh -----
// Assertion macros for the top-level RTL file.
// Each macro takes a label, a clock, a disable condition, an antecedent,
// a consequent and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hdl/mbrtu_pkg.sv -----
`default_nettype none

package mbrtu_pkg;

   localparam int MAX_FRAME_BYTES = 256;
   localparam int MIN_RESPONSE_BYTES = 4;
   localparam int REQUEST_BYTES = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
   localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
   localparam logic [15:0] COUNTER_MAX = 16'hFFFF;

   localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd1;
   localparam logic [7:0] GAP_TICKS_RESET = 8'd5;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

   typedef enum logic [1:0] {
      FUNC_START   = 2'd0,
      FUNC_RX_BYTE = 2'd1,
      FUNC_TICK    = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      KIND_TX      = 2'd0,
      KIND_RX      = 2'd1,
      KIND_TIMEOUT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CRC_ERROR = 2'd1,
      STATUS_TIMEOUT   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_SLAVE_ADDRESS = 2'd0,
      CSR_GAP_TICKS     = 2'd1,
      CSR_TIMEOUT_TICKS = 2'd2
   } csr_index_type;

   // One queued command. For a start command, data_byte carries the slave
   // address and the register fields carry the request parameters.
   typedef struct packed {
      logic        is_start;
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic        last;
      status_type  status;
      logic [15:0] register_address;
      logic [6:0]  register_count;
      logic [15:0] timeout_total;
      logic [15:0] crc_error_total;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // CRC-16 update by one byte, reflected form.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/mbrtu_front.sv -----
`default_nettype none

module mbrtu_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_func,
   input  wire logic [15:0]                  req_register_address,
   input  wire logic [6:0]                   req_register_count,
   input  wire logic [8:0]                   req_response_length,
   input  wire logic [7:0]                   req_rx_byte,
   input  wire logic                         csr_write_enable,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [15:0]                  csr_write_data,
   input  wire mbrtu_pkg::queue_status_type  q_status,
   output logic                              push,
   output mbrtu_pkg::entry_type              push_entry
);

   logic        receiving_ff, receiving_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [8:0]  received_count_ff, received_count_in;
   logic [8:0]  expected_length_ff, expected_length_in;
   logic [16:0] elapsed_ticks_ff, elapsed_ticks_in;
   logic [15:0] timeout_counter_ff, timeout_counter_in;
   logic [15:0] crc_error_counter_ff, crc_error_counter_in;
   logic [7:0]  slave_address_ff, slave_address_in;
   logic [7:0]  gap_ticks_ff, gap_ticks_in;
   logic [15:0] timeout_ticks_ff, timeout_ticks_in;

   logic        accept;
   logic [15:0] crc_next;
   logic [8:0]  count_next;
   logic [16:0] elapsed_next;
   logic [16:0] limit;
   logic [8:0]  length_clamped;

   assign req_stall = q_status.full;
   assign accept = req_valid && !req_stall;

   assign crc_next = mbrtu_pkg::crc_byte(running_crc_ff, req_rx_byte);
   assign count_next = received_count_ff + 9'd1;
   assign elapsed_next = (elapsed_ticks_ff != mbrtu_pkg::ELAPSED_MAX) ?
                         elapsed_ticks_ff + 17'd1 : elapsed_ticks_ff;
   assign limit = {9'd0, gap_ticks_ff} + {1'b0, timeout_ticks_ff};

   always_comb begin
      if (req_response_length < 9'(mbrtu_pkg::MIN_RESPONSE_BYTES)) begin
         length_clamped = 9'(mbrtu_pkg::MIN_RESPONSE_BYTES);
      end else if (req_response_length > 9'(mbrtu_pkg::MAX_FRAME_BYTES)) begin
         length_clamped = 9'(mbrtu_pkg::MAX_FRAME_BYTES);
      end else begin
         length_clamped = req_response_length;
      end
   end

   always_comb begin
      slave_address_in = slave_address_ff;
      gap_ticks_in = gap_ticks_ff;
      timeout_ticks_in = timeout_ticks_ff;
      if (csr_write_enable) begin
         unique case (mbrtu_pkg::csr_index_type'(csr_index))
            mbrtu_pkg::CSR_SLAVE_ADDRESS: slave_address_in = csr_write_data[7:0];
            mbrtu_pkg::CSR_GAP_TICKS:     gap_ticks_in = csr_write_data[7:0];
            mbrtu_pkg::CSR_TIMEOUT_TICKS: timeout_ticks_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      receiving_in = receiving_ff;
      running_crc_in = running_crc_ff;
      received_count_in = received_count_ff;
      expected_length_in = expected_length_ff;
      elapsed_ticks_in = elapsed_ticks_ff;
      timeout_counter_in = timeout_counter_ff;
      crc_error_counter_in = crc_error_counter_ff;
      push = 1'b0;
      push_entry = '0;
      push_entry.register_address = req_register_address;
      push_entry.register_count = req_register_count;
      push_entry.byte_index = received_count_ff[7:0];
      if (accept) begin
         unique case (mbrtu_pkg::func_type'(req_func))
            mbrtu_pkg::FUNC_START: begin
               receiving_in = 1'b1;
               running_crc_in = mbrtu_pkg::CRC_INIT;
               received_count_in = 9'd0;
               expected_length_in = length_clamped;
               elapsed_ticks_in = 17'd0;
               push = 1'b1;
               push_entry.is_start = 1'b1;
               push_entry.kind = mbrtu_pkg::KIND_TX;
               push_entry.data_byte = slave_address_ff;
               push_entry.byte_index = 8'd0;
            end
            mbrtu_pkg::FUNC_RX_BYTE: begin
               if (receiving_ff) begin
                  running_crc_in = crc_next;
                  received_count_in = count_next;
                  push = 1'b1;
                  push_entry.kind = mbrtu_pkg::KIND_RX;
                  push_entry.data_byte = req_rx_byte;
                  if (count_next >= expected_length_ff) begin
                     receiving_in = 1'b0;
                     push_entry.last = 1'b1;
                     if (crc_next != 16'd0) begin
                        push_entry.status = mbrtu_pkg::STATUS_CRC_ERROR;
                        if (crc_error_counter_ff != mbrtu_pkg::COUNTER_MAX) begin
                           crc_error_counter_in = crc_error_counter_ff + 16'd1;
                        end
                     end
                  end
               end
            end
            mbrtu_pkg::FUNC_TICK: begin
               if (receiving_ff) begin
                  elapsed_ticks_in = elapsed_next;
                  if (elapsed_next >= limit) begin
                     receiving_in = 1'b0;
                     if (timeout_counter_ff != mbrtu_pkg::COUNTER_MAX) begin
                        timeout_counter_in = timeout_counter_ff + 16'd1;
                     end
                     push = 1'b1;
                     push_entry.kind = mbrtu_pkg::KIND_TIMEOUT;
                     push_entry.last = 1'b1;
                     push_entry.status = mbrtu_pkg::STATUS_TIMEOUT;
                  end
               end
            end
            default: ;
         endcase
      end
      push_entry.timeout_total = timeout_counter_in;
      push_entry.crc_error_total = crc_error_counter_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         running_crc_ff <= mbrtu_pkg::CRC_INIT;
         received_count_ff <= 9'd0;
         expected_length_ff <= 9'd0;
         elapsed_ticks_ff <= 17'd0;
         timeout_counter_ff <= 16'd0;
         crc_error_counter_ff <= 16'd0;
         slave_address_ff <= mbrtu_pkg::SLAVE_ADDRESS_RESET;
         gap_ticks_ff <= mbrtu_pkg::GAP_TICKS_RESET;
         timeout_ticks_ff <= mbrtu_pkg::TIMEOUT_TICKS_RESET;
      end else begin
         receiving_ff <= receiving_in;
         running_crc_ff <= running_crc_in;
         received_count_ff <= received_count_in;
         expected_length_ff <= expected_length_in;
         elapsed_ticks_ff <= elapsed_ticks_in;
         timeout_counter_ff <= timeout_counter_in;
         crc_error_counter_ff <= crc_error_counter_in;
         slave_address_ff <= slave_address_in;
         gap_ticks_ff <= gap_ticks_in;
         timeout_ticks_ff <= timeout_ticks_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/mbrtu_queue.sv -----
`default_nettype none

module mbrtu_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire mbrtu_pkg::entry_type  push_entry,
   input  wire logic                  pop,
   output mbrtu_pkg::entry_type       head,
   output mbrtu_pkg::queue_status_type q_status
);

   localparam int PW = mbrtu_pkg::QUEUE_PTR_W;

   mbrtu_pkg::entry_type entries_ff [mbrtu_pkg::QUEUE_DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   assign head = entries_ff[rd_ptr_ff];
   assign q_status.full = (count_ff == (PW+1)'(mbrtu_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/mbrtu_back.sv -----
`default_nettype none

module mbrtu_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mbrtu_pkg::entry_type       head,
   input  wire mbrtu_pkg::queue_status_type q_status,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic [7:0]                      rsp_data_byte,
   output logic [7:0]                      rsp_byte_index,
   output logic                            rsp_last,
   output logic [1:0]                      rsp_status,
   output logic [15:0]                     rsp_timeout_total,
   output logic [15:0]                     rsp_crc_error_total
);

   // Request expansion registers.
   logic        tx_active_ff, tx_active_in;
   logic [2:0]  tx_pos_ff, tx_pos_in;
   logic [15:0] tx_crc_ff, tx_crc_in;
   logic [7:0]  tx_slave_ff, tx_slave_in;
   logic [15:0] tx_addr_ff, tx_addr_in;
   logic [6:0]  tx_cnt_ff, tx_cnt_in;
   logic [15:0] tx_tot_ff, tx_tot_in;
   logic [15:0] tx_crc_tot_ff, tx_crc_tot_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   mbrtu_pkg::entry_type  out_ff, out_in;

   logic       load;
   logic [7:0] tx_data;

   assign load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (tx_pos_ff)
         3'd0: tx_data = tx_slave_ff;
         3'd1: tx_data = mbrtu_pkg::FUNC_READ_HOLDING;
         3'd2: tx_data = tx_addr_ff[15:8];
         3'd3: tx_data = tx_addr_ff[7:0];
         3'd4: tx_data = 8'h00;
         3'd5: tx_data = {1'b0, tx_cnt_ff};
         3'd6: tx_data = tx_crc_ff[7:0];
         default: tx_data = tx_crc_ff[15:8];
      endcase
   end

   always_comb begin
      tx_active_in = tx_active_ff;
      tx_pos_in = tx_pos_ff;
      tx_crc_in = tx_crc_ff;
      tx_slave_in = tx_slave_ff;
      tx_addr_in = tx_addr_ff;
      tx_cnt_in = tx_cnt_ff;
      tx_tot_in = tx_tot_ff;
      tx_crc_tot_in = tx_crc_tot_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in = out_ff;
      pop = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b0;
         if (tx_active_ff) begin
            rsp_valid_in = 1'b1;
            out_in = '0;
            out_in.kind = mbrtu_pkg::KIND_TX;
            out_in.data_byte = tx_data;
            out_in.byte_index = {5'd0, tx_pos_ff};
            out_in.last = (tx_pos_ff == 3'(mbrtu_pkg::REQUEST_BYTES - 1));
            out_in.timeout_total = tx_tot_ff;
            out_in.crc_error_total = tx_crc_tot_ff;
            if (tx_pos_ff <= 3'd5) begin
               tx_crc_in = mbrtu_pkg::crc_byte(tx_crc_ff, tx_data);
            end
            tx_pos_in = tx_pos_ff + 3'd1;
            tx_active_in = !out_in.last;
         end else if (!q_status.empty) begin
            rsp_valid_in = 1'b1;
            pop = 1'b1;
            out_in = head;
            if (head.is_start) begin
               // Byte 0 goes out now; the rest follow from the expansion.
               tx_active_in = 1'b1;
               tx_pos_in = 3'd1;
               tx_crc_in = mbrtu_pkg::crc_byte(mbrtu_pkg::CRC_INIT, head.data_byte);
               tx_slave_in = head.data_byte;
               tx_addr_in = head.register_address;
               tx_cnt_in = head.register_count;
               tx_tot_in = head.timeout_total;
               tx_crc_tot_in = head.crc_error_total;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      tx_pos_ff <= tx_pos_in;
      tx_crc_ff <= tx_crc_in;
      tx_slave_ff <= tx_slave_in;
      tx_addr_ff <= tx_addr_in;
      tx_cnt_ff <= tx_cnt_in;
      tx_tot_ff <= tx_tot_in;
      tx_crc_tot_ff <= tx_crc_tot_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tx_active_ff <= tx_active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = out_ff.kind;
   assign rsp_data_byte = out_ff.data_byte;
   assign rsp_byte_index = out_ff.byte_index;
   assign rsp_last = out_ff.last;
   assign rsp_status = out_ff.status;
   assign rsp_timeout_total = out_ff.timeout_total;
   assign rsp_crc_error_total = out_ff.crc_error_total;

endmodule

`default_nettype wire

// ----- hdl/modbus_rtu_read_holding_master_top.sv -----
// Channel  Dir  Handshake     Transfer contents
// req_     in   valid, stall  func, register address, count, response length, rx byte
// rsp_     out  valid, stall  kind, data byte, index, last, status, both error totals
// csr_     in   write enable  register index, 16-bit write data
//
// A received byte or a tick yields at most one transfer; a start yields eight
// request bytes, one per output cycle.
// A result goes through the command queue and the output register to rsp_valid.
// The four-entry command queue lets the front run ahead of the back; req_stall rises
// only while the queue is full, and a stalled output holds its transfer unchanged.
// Synchronous active-high reset restores control state, CSRs and both counters.
`default_nettype none

`include "assert_macros.svh"

module modbus_rtu_read_holding_master_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel.
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [15:0] req_register_address,
   input  wire logic [6:0]  req_register_count,
   input  wire logic [8:0]  req_response_length,
   input  wire logic [7:0]  req_rx_byte,
   // Result channel.
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [7:0]       rsp_byte_index,
   output logic             rsp_last,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_timeout_total,
   output logic [15:0]      rsp_crc_error_total,
   // Configuration port.
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   // The front owns the transaction state and the configuration registers.
   // Every accepted item that produces output pushes one command; the
   // counter values in a command are those after the item's own update.
   logic                        push;
   logic                        pop;
   mbrtu_pkg::entry_type        push_entry;
   mbrtu_pkg::entry_type        head;
   mbrtu_pkg::queue_status_type q_status;

   mbrtu_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_register_address (req_register_address),
      .req_register_count   (req_register_count),
      .req_response_length  (req_response_length),
      .req_rx_byte          (req_rx_byte),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .q_status             (q_status),
      .push                 (push),
      .push_entry           (push_entry)
   );

   mbrtu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   // The back expands a start command into the eight request bytes,
   // running the request CRC one byte per cycle while the output is not stalled, and
   // passes every other command straight to the output register.
   mbrtu_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .q_status            (q_status),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_byte_index      (rsp_byte_index),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status),
      .rsp_timeout_total   (rsp_timeout_total),
      .rsp_crc_error_total (rsp_crc_error_total)
   );

   // Once a request byte other than the final one is transferred, the next
   // request byte follows in the very next cycle.
   `ASSERT_NEXT(a_tx_back_to_back, clock, reset,
      rsp_valid && !rsp_stall && (rsp_kind == mbrtu_pkg::KIND_TX) && !rsp_last,
      rsp_valid && (rsp_kind == mbrtu_pkg::KIND_TX)
         && (rsp_byte_index == $past(rsp_byte_index) + 8'd1),
      "request bytes are not contiguous")

   // A timeout end always closes the transaction with timeout status.
   `ASSERT_IMPLY(a_timeout_end, clock, reset,
      rsp_valid && (rsp_kind == mbrtu_pkg::KIND_TIMEOUT),
      rsp_last && (rsp_status == mbrtu_pkg::STATUS_TIMEOUT),
      "timeout end without last or timeout status")

   // Saturating counters never go backward from one transfer to the next.
   `ASSERT_IMPLY(a_counters_monotonic, clock, reset,
      (rsp_valid && !rsp_stall) ##1 rsp_valid,
      (rsp_timeout_total >= $past(rsp_timeout_total))
         && (rsp_crc_error_total >= $past(rsp_crc_error_total)),
      "error counters decreased")

endmodule

`default_nettype wire

// ----- tb/modbus_rtu_read_holding_master_top_tb.sv -----
module modbus_rtu_read_holding_master_top_tb;
   import mbrtu_pkg::*;

   // Function code that the block does not use; it must be dropped silently.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   // Cycles allowed after the last expected transfer; ticks and bytes that
   // produce nothing never enter the command queue.
   localparam int SETTLE_CYCLES = 20;

   // One result transfer, field by field.
   typedef struct {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic        last;
      status_type  status;
      logic [15:0] timeout_total;
      logic [15:0] crc_error_total;
   } master_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_TICK;
   logic [15:0] req_register_address = '0;
   logic [6:0]  req_register_count = '0;
   logic [8:0]  req_response_length = '0;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_byte_index;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_timeout_total;
   logic [15:0] rsp_crc_error_total;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_SLAVE_ADDRESS;
   logic [15:0] csr_write_data = '0;

   modbus_rtu_read_holding_master_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_register_address(req_register_address),
      .req_register_count(req_register_count),
      .req_response_length(req_response_length),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_data_byte(rsp_data_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_last(rsp_last),
      .rsp_status(rsp_status),
      .rsp_timeout_total(rsp_timeout_total),
      .rsp_crc_error_total(rsp_crc_error_total),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // Register copies kept by the testbench. They only change while the
   // block is idle, so the predictor can use them directly.
   logic [7:0]  cfg_slave_address;
   logic [7:0]  cfg_gap_ticks;
   logic [15:0] cfg_timeout_ticks;

   // Transaction state of the predicted master.
   bit          rx_active;
   logic [15:0] rx_crc;
   logic [8:0]  rx_count;
   logic [8:0]  rx_length;
   logic [16:0] rx_elapsed;
   logic [15:0] timeout_tally;
   logic [15:0] crc_error_tally;

   // Transfers that the block still owes, oldest first.
   master_rsp_type expected_rsp[$];
   // Response frame that the current test feeds back to the master.
   logic [7:0]  resp_bytes[$];

   int fail_count = 0;
   int items_sent = 0;
   // Idle percentages of the two sides; the test sequence changes them.
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   // A test asks for a long receiver hold-off here; the receiver process
   // takes the request and counts it down on its own.
   int hold_request = 0;
   int stall_left = 0;

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic void reset_model();
      cfg_slave_address = SLAVE_ADDRESS_RESET;
      cfg_gap_ticks = GAP_TICKS_RESET;
      cfg_timeout_ticks = TIMEOUT_TICKS_RESET;
      rx_active = 1'b0;
      rx_crc = CRC_INIT;
      rx_count = '0;
      rx_length = '0;
      rx_elapsed = '0;
      timeout_tally = '0;
      crc_error_tally = '0;
   endfunction

   // Queues one expected transfer; the counter fields always carry the totals
   // as they stand after the current item's update.
   function automatic void expect_rsp(input kind_type kind, input logic [7:0] data,
         input logic [7:0] index, input logic last, input status_type status);
      master_rsp_type r;
      r.kind = kind;
      r.data_byte = data;
      r.byte_index = index;
      r.last = last;
      r.status = status;
      r.timeout_total = timeout_tally;
      r.crc_error_total = crc_error_tally;
      expected_rsp.push_back(r);
   endfunction

   // Works out what the master does with one accepted item.
   function automatic void predict_master(input logic [1:0] func, input logic [15:0] addr,
         input logic [6:0] count, input logic [8:0] rlen, input logic [7:0] data);
      logic [7:0]  frame[8];
      logic [15:0] crc;
      logic [7:0]  index;
      status_type  status;
      case (func)
         FUNC_START: begin
            frame[0] = cfg_slave_address;
            frame[1] = FUNC_READ_HOLDING;
            frame[2] = addr[15:8];
            frame[3] = addr[7:0];
            frame[4] = 8'h00;
            frame[5] = {1'b0, count};
            crc = CRC_INIT;
            for (int i = 0; i < 6; i++) crc = crc16_step(crc, frame[i]);
            frame[6] = crc[7:0];
            frame[7] = crc[15:8];
            // A start always wins, even over a pending exchange, which is
            // dropped without touching either counter.
            rx_active = 1'b1;
            rx_crc = CRC_INIT;
            rx_count = '0;
            rx_elapsed = '0;
            if (rlen < MIN_RESPONSE_BYTES) rx_length = 9'(MIN_RESPONSE_BYTES);
            else if (rlen > MAX_FRAME_BYTES) rx_length = 9'(MAX_FRAME_BYTES);
            else rx_length = rlen;
            for (int i = 0; i < REQUEST_BYTES; i++)
               expect_rsp(KIND_TX, frame[i], 8'(i), i == REQUEST_BYTES - 1, STATUS_OK);
         end
         FUNC_RX_BYTE: begin
            if (rx_active) begin
               index = rx_count[7:0];
               rx_crc = crc16_step(rx_crc, data);
               rx_count = rx_count + 9'd1;
               if (rx_count >= rx_length) begin
                  // A good frame folds its own CRC into a zero residue.
                  rx_active = 1'b0;
                  status = STATUS_OK;
                  if (rx_crc != 16'h0000) begin
                     status = STATUS_CRC_ERROR;
                     if (crc_error_tally != COUNTER_MAX) crc_error_tally++;
                  end
                  expect_rsp(KIND_RX, data, index, 1'b1, status);
               end else begin
                  expect_rsp(KIND_RX, data, index, 1'b0, STATUS_OK);
               end
            end
         end
         FUNC_TICK: begin
            if (rx_active) begin
               if (rx_elapsed != ELAPSED_MAX) rx_elapsed++;
               if (int'(rx_elapsed) >= int'(cfg_gap_ticks) + int'(cfg_timeout_ticks)) begin
                  rx_active = 1'b0;
                  if (timeout_tally != COUNTER_MAX) timeout_tally++;
                  expect_rsp(KIND_TIMEOUT, 8'h00, rx_count[7:0], 1'b1, STATUS_TIMEOUT);
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
         input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Both handshakes are sampled at the rising edge, before anything that the
   // edge itself schedules takes effect. An item accepted at an edge is
   // predicted before a transfer at the same edge is checked.
   always @(posedge clock) begin : monitor
      master_rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            predict_master(req_func, req_register_address, req_register_count,
                           req_response_length, req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("transfer with nothing expected: kind %0d data %0h index %0d",
                      rsp_kind, rsp_data_byte, rsp_byte_index);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp_kind));
               check_field("data_byte", 16'(want.data_byte), 16'(rsp_data_byte));
               check_field("byte_index", 16'(want.byte_index), 16'(rsp_byte_index));
               check_field("last", 16'(want.last), 16'(rsp_last));
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("timeout_total", want.timeout_total, rsp_timeout_total);
               check_field("crc_error_total", want.crc_error_total, rsp_crc_error_total);
            end
         end
      end
   end

   // Receiver side. It stalls at random, or solidly for as many cycles as a
   // test asks for, so that the block's queue fills and it stalls its input.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Offers one item and returns at the edge where it is accepted. Valid is
   // left high so that a following item goes out without a gap; random idle
   // cycles are inserted before the item instead.
   task automatic send_item(input logic [1:0] func, input logic [15:0] addr,
         input logic [6:0] count, input logic [8:0] rlen, input logic [7:0] data);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_register_address <= addr;
      req_register_count <= count;
      req_response_length <= rlen;
      req_rx_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // The fields that an item does not use still carry random values.
   task automatic send_start(input logic [15:0] addr, input logic [6:0] count,
         input logic [8:0] rlen);
      send_item(FUNC_START, addr, count, rlen, 8'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] data);
      send_item(FUNC_RX_BYTE, 16'($urandom), 7'($urandom), 9'($urandom), data);
   endtask

   task automatic send_tick();
      send_item(FUNC_TICK, 16'($urandom), 7'($urandom), 9'($urandom), 8'($urandom));
   endtask

   // Builds a response frame of len bytes: slave address, function code,
   // random body and a trailing CRC, low byte first. A corrupt frame has one
   // bit flipped somewhere, which a CRC-16 always catches.
   function automatic void build_response(input int len, input bit corrupt);
      logic [15:0] crc;
      int pos;
      resp_bytes.delete();
      resp_bytes.push_back(cfg_slave_address);
      resp_bytes.push_back(FUNC_READ_HOLDING);
      repeat (len - 4) resp_bytes.push_back(8'($urandom));
      crc = CRC_INIT;
      foreach (resp_bytes[i]) crc = crc16_step(crc, resp_bytes[i]);
      resp_bytes.push_back(crc[7:0]);
      resp_bytes.push_back(crc[15:8]);
      if (corrupt) begin
         pos = $urandom_range(len - 1);
         resp_bytes[pos] = resp_bytes[pos] ^ (8'h01 << $urandom_range(7));
      end
   endfunction

   // Feeds the first n bytes of the frame, with ticks mixed in at random.
   task automatic send_response(input int n, input int tick_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < tick_pct) send_tick();
         send_byte(resp_bytes[i]);
      end
   endtask

   // Waits until every expected transfer has arrived, then idles for the
   // SETTLE_CYCLES margin; items that produce nothing never enter the queue.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves the master idle: an open exchange is finished with filler bytes,
   // so a register change never lands in the middle of one.
   task automatic settle();
      int missing;
      wait_idle();
      if (rx_active) begin
         missing = int'(rx_length) - int'(rx_count);
         repeat (missing) send_byte(8'($urandom));
         wait_idle();
      end
   endtask

   task automatic write_csr(input csr_index_type index, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_SLAVE_ADDRESS: cfg_slave_address = value[7:0];
         CSR_GAP_TICKS: cfg_gap_ticks = value[7:0];
         CSR_TIMEOUT_TICKS: cfg_timeout_ticks = value;
         default: begin
         end
      endcase
   endtask

   task automatic configure(input logic [7:0] slave, input logic [7:0] gap,
         input logic [15:0] timeout);
      settle();
      write_csr(CSR_SLAVE_ADDRESS, {8'h00, slave});
      write_csr(CSR_GAP_TICKS, {8'h00, gap});
      write_csr(CSR_TIMEOUT_TICKS, timeout);
   endtask

   // Bytes, ticks and the unused function code while idle all vanish.
   task automatic test_idle_inputs();
      send_byte(8'hFF);
      send_tick();
      send_item(FUNC_UNUSED, 16'hFFFF, 7'h7F, 9'h1FF, 8'hFF);
      wait_idle();
   endtask

   // Reset registers, all-zero request fields and a response length below
   // the minimum, which the master raises to four; the reply is good.
   task automatic test_default_request();
      send_start(16'h0000, 7'd0, 9'd0);
      build_response(4, 1'b0);
      send_response(4, 0);
      settle();
   endtask

   // Highest slave address and all-ones request fields, then a damaged reply.
   task automatic test_crc_error();
      configure(8'd247, GAP_TICKS_RESET, TIMEOUT_TICKS_RESET);
      send_start(16'hFFFF, 7'h7F, 9'd5);
      build_response(5, 1'b1);
      send_response(5, 0);
      settle();
   endtask

   // With no gap and no timeout window the first tick ends the exchange. The
   // length above the frame limit is clipped, so one byte is far from done.
   task automatic test_zero_timeout();
      configure(8'($urandom_range(247)), 8'd0, 16'd0);
      send_start(16'h5AA5, 7'h2A, 9'h1FF);
      send_byte(8'($urandom));
      send_tick();
      settle();
   endtask

   // A second start abandons the first exchange without counting it.
   task automatic test_restart();
      send_start(16'($urandom), 7'($urandom), 9'd6);
      send_byte(8'($urandom));
      send_start(16'($urandom), 7'($urandom), 9'd300);
      send_tick();
      settle();
   endtask

   // The receiver holds off for a long stretch while starts keep coming, so
   // the command queue fills and the input stalls.
   task automatic test_backpressure();
      hold_request = 300;
      repeat (12) send_start(16'($urandom), 7'($urandom), 9'($urandom_range(12, 4)));
      send_tick();
      settle();
   endtask

   // Mostly well-formed exchanges with random content; some replies are
   // damaged, cut short, left to time out or abandoned by a new start, and
   // about one round in ten is a single noise item of any kind.
   task automatic run_random_traffic(input int items);
      int first;
      int len;
      int stop_at;
      int window;
      logic [8:0] rlen;
      first = items_sent;
      while (items_sent - first < items) begin
         if ($urandom_range(9) == 0) begin
            send_item(2'($urandom_range(3)), 16'($urandom), 7'($urandom), 9'($urandom),
                      8'($urandom));
         end else begin
            // Long frames are rare so that the run stays short.
            case ($urandom_range(99))
               0: rlen = 9'($urandom_range(511, 200));
               1, 2, 3: rlen = 9'($urandom_range(3));
               4, 5, 6, 7, 8, 9, 10, 11: rlen = 9'($urandom_range(40, 13));
               default: rlen = 9'($urandom_range(12, 4));
            endcase
            if (rlen < MIN_RESPONSE_BYTES) len = MIN_RESPONSE_BYTES;
            else if (rlen > MAX_FRAME_BYTES) len = MAX_FRAME_BYTES;
            else len = int'(rlen);
            build_response(len, $urandom_range(4) == 0);
            send_start(16'($urandom), 7'($urandom), rlen);
            stop_at = ($urandom_range(9) < 2) ? $urandom_range(len - 1) : len;
            send_response(stop_at, 8);
            // A cut-short reply is either left to the next start or ticked
            // out, where the window is short enough to do so.
            window = int'(cfg_gap_ticks) + int'(cfg_timeout_ticks);
            if (stop_at < len && window <= 40 && $urandom_range(1) == 1)
               repeat (window + 1) send_tick();
         end
      end
   endtask

   task automatic test_random_fast_timeouts();
      configure(8'($urandom_range(247)), 8'd2, 16'd1);
      send_gap_pct = 7;
      rsp_stall_pct = 45;
      run_random_traffic(100);
      settle();
   endtask

   task automatic test_random_short_window();
      configure(8'd0, 8'd0, 16'd12);
      send_gap_pct = 45;
      rsp_stall_pct = 7;
      run_random_traffic(100);
      settle();
   endtask

   task automatic test_random_no_timeout();
      configure(8'd247, 8'd255, 16'hFFFF);
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      run_random_traffic(100);
      settle();
   endtask

   initial begin
      reset_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_gap_pct = 7;
      rsp_stall_pct = 45;
      test_idle_inputs();
      test_default_request();
      test_crc_error();
      test_zero_timeout();
      test_restart();
      test_backpressure();
      test_random_fast_timeouts();
      test_random_short_window();
      test_random_no_timeout();
      wait_idle();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // A hung handshake ends the run here.
   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
